FILE: src/assert_macros.svh
// Assertion macros for the RTL of the key remapper.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define KBR_ASSERT(lbl, clk, rstn, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) \
    else $error("kbr assertion failed");
`define KBR_NEVER(lbl, clk, rstn, expr) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) !(expr)) \
    else $error("kbr forbidden condition seen");
`else
`define KBR_ASSERT(lbl, clk, rstn, prop)
`define KBR_NEVER(lbl, clk, rstn, expr)
`endif
`endif

FILE: src/kbr_pkg.sv
// Types, key codes and the Dvorak table of the key remapper.
`default_nettype none
package kbr_pkg;

  localparam int unsigned CODE_W = 10;
  localparam int unsigned TYPE_W = 5;
  localparam int unsigned VAL_W  = 32;
  localparam int unsigned MOD_W  = 5;

  localparam logic [TYPE_W-1:0] EVT_KEY = 5'd1;
  localparam logic [TYPE_W-1:0] EVT_LED = 5'd17;

  localparam logic [CODE_W-1:0] K_ESC    = 10'd1;
  localparam logic [CODE_W-1:0] K_ENTER  = 10'd28;
  localparam logic [CODE_W-1:0] K_CAPS   = 10'd58;
  localparam logic [CODE_W-1:0] K_SCROLL = 10'd70;
  localparam logic [CODE_W-1:0] K_KATA   = 10'd90;
  localparam logic [CODE_W-1:0] K_HIRA   = 10'd91;
  localparam logic [CODE_W-1:0] K_LCTRL  = 10'd29;
  localparam logic [CODE_W-1:0] K_RCTRL  = 10'd97;
  localparam logic [CODE_W-1:0] K_LALT   = 10'd56;
  localparam logic [CODE_W-1:0] K_LMETA  = 10'd125;
  localparam logic [CODE_W-1:0] K_RMETA  = 10'd126;

  localparam logic [CODE_W-1:0] LED_LOCK  = 10'd1;
  localparam logic [CODE_W-1:0] LED_DUMMY = 10'd3;

  localparam logic [MOD_W-1:0] MOD_LCTRL = 5'b00001;
  localparam logic [MOD_W-1:0] MOD_RCTRL = 5'b00010;
  localparam logic [MOD_W-1:0] MOD_LALT  = 5'b00100;
  localparam logic [MOD_W-1:0] MOD_LMETA = 5'b01000;
  localparam logic [MOD_W-1:0] MOD_RMETA = 5'b10000;
  localparam logic [MOD_W-1:0] MOD_CTRL_M = MOD_LCTRL | MOD_RCTRL;
  localparam logic [MOD_W-1:0] MOD_META_M = MOD_LMETA | MOD_RMETA;

  localparam logic [VAL_W-1:0] VAL_RELEASE = 32'd0;
  localparam logic [VAL_W-1:0] VAL_PRESS   = 32'd1;
  localparam logic [VAL_W-1:0] VAL_REPEAT  = 32'd2;

  // Dvorak codes for QWERTY codes 12..53, zero keeps the code
  localparam logic [CODE_W-1:0] DV_LO = 10'd12;
  localparam logic [CODE_W-1:0] DV_HI = 10'd53;
  localparam logic [CODE_W-1:0] DV_MAP [42] = '{
    10'd26, 10'd27, 10'd0,  10'd0,
    10'd40, 10'd51, 10'd52, 10'd25, 10'd21, 10'd33, 10'd34, 10'd46,
    10'd19, 10'd38, 10'd53, 10'd13,
    10'd0,  10'd0,
    10'd30, 10'd24, 10'd18, 10'd22, 10'd23, 10'd32, 10'd35, 10'd20,
    10'd49, 10'd31, 10'd12,
    10'd0,  10'd0,  10'd0,
    10'd39, 10'd16, 10'd36, 10'd37, 10'd45, 10'd48, 10'd50, 10'd17,
    10'd47, 10'd44
  };

  typedef enum logic [1:0] {
    ACT_NONE,
    ACT_PUSH,
    ACT_REPEAT,
    ACT_RELEASE
  } act_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_RD,
    ST_CMP,
    ST_FIN
  } state_e;

  typedef struct packed {
    logic             lock;
    logic             caps;
    logic             ent;
    logic             phase;
    logic [MOD_W-1:0] mods;
  } flags_t;

  typedef struct packed {
    logic              led1;
    logic              led1_val;
    logic              led3;
    logic              led3_val;
    logic              fwd;
    act_e              act;
    logic [CODE_W-1:0] dv;
    logic [CODE_W-1:0] fcode;
  } plan_t;

  typedef struct packed {
    logic              led1;
    logic              led1_val;
    logic              led3;
    logic              led3_val;
    logic              fwd;
    logic [TYPE_W-1:0] ev_type;
    logic [CODE_W-1:0] code;
    logic [VAL_W-1:0]  value;
  } emit_req_t;

  typedef struct packed {
    logic fwd;
    logic led3;
    logic led1;
  } pend_t;

  function automatic logic [CODE_W-1:0] dvorak_of(input logic [CODE_W-1:0] code);
    logic [CODE_W-1:0] off;
    logic [CODE_W-1:0] m;
    off = code - DV_LO;
    m   = DV_MAP[off[5:0]];
    if (code >= DV_LO && code <= DV_HI && m != '0) begin
      return m;
    end
    return code;
  endfunction

  function automatic logic [MOD_W-1:0] mod_bit(input logic [CODE_W-1:0] code);
    logic [MOD_W-1:0] mb;
    mb = '0;
    if (code == K_LCTRL) mb = MOD_LCTRL;
    if (code == K_RCTRL) mb = MOD_RCTRL;
    if (code == K_LALT)  mb = MOD_LALT;
    if (code == K_LMETA) mb = MOD_LMETA;
    if (code == K_RMETA) mb = MOD_RMETA;
    return mb;
  endfunction

endpackage
`default_nettype wire

FILE: src/keyboard_layout_remapper_core.sv
// Top level of the QWERTY to Dvorak key remapper.
//
//  port group    dir  handshake              payload
//  input item    in   in_valid_i/in_ready_o  event_type_i, key_code_i, event_value_i
//  result item   out  out_valid_o/out_ready_i destination_o, out_type_o, out_code_o,
//                                            out_value_o, last_o
//  config        in   APB psel/penable/pwrite paddr, pwdata, prdata
//
// One item at a time. The item is decoded in its accept cycle; a press pushes into the
// held table at the accept edge. A release or repeat then walks the held table entry by
// entry (read, then compare/write) through the registered memory read port; a repeat
// stops at its first match. The FIN state hands the results to the sequencer, which holds
// them as pending results and registers each one out. Results (0 to 3 per item) leave one
// per cycle while out_ready_i is high; the next item is taken once the sequencer holds no
// pending result, even if the last one still waits downstream.
// Reset: asynchronous, active low; lock starts on. The held table is tracked by a
// fill count, so the memory needs no clearing pass after reset.
`default_nettype none
`include "assert_macros.svh"
module keyboard_layout_remapper_core import kbr_pkg::*; #(
  parameter int unsigned TABLE_DEPTH = 32
) (
  input  wire logic                     clk_i,
  input  wire logic                     rst_ni,
  // input item channel
  input  wire logic                     in_valid_i,
  output      logic                     in_ready_o,
  input  wire logic        [TYPE_W-1:0] event_type_i,
  input  wire logic        [CODE_W-1:0] key_code_i,
  input  wire logic signed [VAL_W-1:0]  event_value_i,
  // result item channel
  output      logic                     out_valid_o,
  input  wire logic                     out_ready_i,
  output      logic                     destination_o,
  output      logic        [TYPE_W-1:0] out_type_o,
  output      logic        [CODE_W-1:0] out_code_o,
  output      logic signed [VAL_W-1:0]  out_value_o,
  output      logic                     last_o,
  // configuration port
  input  wire logic                     psel,
  input  wire logic                     penable,
  input  wire logic                     pwrite,
  input  wire logic        [2:0]        paddr,
  input  wire logic        [31:0]       pwdata,
  output      logic        [31:0]       prdata,
  output      logic                     pready
);

  localparam int unsigned CNT_W  = $clog2(TABLE_DEPTH + 1);
  localparam int unsigned ADDR_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;

  // config registers
  logic tme_q;
  logic dle_q;
  logic cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;
  assign prdata = paddr[2] ? {31'b0, dle_q} : {31'b0, tme_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tme_q <= 1'b0;
      dle_q <= 1'b0;
    end else if (cfg_wr) begin
      if (paddr[2]) begin
        dle_q <= pwdata[0];
      end else begin
        tme_q <= pwdata[0];
      end
    end
  end

  // control state
  state_e                   st_q, st_d;
  flags_t                   flags_q, flags_d;
  logic        [CNT_W-1:0]  held_cnt_q, held_cnt_d;
  logic        [ADDR_W-1:0] idx_q, idx_d;
  logic        [CNT_W-1:0]  top_q, top_d;
  logic                     found_q, found_d;
  // per-item payload
  plan_t                    plan_q, plan_d;
  logic        [TYPE_W-1:0] type_q, type_d;
  logic signed [VAL_W-1:0]  val_q, val_d;
  logic        [CODE_W-1:0] fcode_q, fcode_d;

  flags_t                   dec_flags;
  plan_t                    dec_plan;
  logic                     table_full;
  logic                     emit_busy;
  logic                     emit_start;
  emit_req_t                emit_req;

  logic                     mem_we;
  logic        [ADDR_W-1:0] mem_waddr;
  logic        [CODE_W-1:0] mem_wdata;
  logic                     mem_re;
  logic        [ADDR_W-1:0] mem_raddr;
  logic        [CODE_W-1:0] mem_rdata;

  logic                     hit;
  logic                     last_ent;
  logic        [CNT_W-1:0]  idx_ext;
  logic                     push_acc;

  assign table_full = (held_cnt_q >= CNT_W'(TABLE_DEPTH));

  kbr_evt_decode u_dec (
    .event_type_i  (event_type_i),
    .key_code_i    (key_code_i),
    .event_value_i (event_value_i),
    .toggle_en_i   (tme_q),
    .dummy_en_i    (dle_q),
    .table_full_i  (table_full),
    .flags_i       (flags_q),
    .flags_o       (dec_flags),
    .plan_o        (dec_plan)
  );

  kbr_held_mem #(
    .DEPTH  (TABLE_DEPTH),
    .ADDR_W (ADDR_W)
  ) u_mem (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .re_i    (mem_re),
    .raddr_i (mem_raddr),
    .rdata_o (mem_rdata)
  );

  always_comb begin
    st_d       = st_q;
    flags_d    = flags_q;
    held_cnt_d = held_cnt_q;
    idx_d      = idx_q;
    top_d      = top_q;
    found_d    = found_q;
    plan_d     = plan_q;
    type_d     = type_q;
    val_d      = val_q;
    fcode_d    = fcode_q;
    mem_we     = 1'b0;
    mem_waddr  = idx_q;
    mem_wdata  = '0;
    mem_re     = 1'b0;
    mem_raddr  = idx_q;
    emit_start = 1'b0;
    in_ready_o = (st_q == ST_IDLE) && !emit_busy;
    idx_ext    = CNT_W'(idx_q);
    last_ent   = ((idx_ext + CNT_W'(1)) == held_cnt_q);
    hit        = (mem_rdata == plan_q.dv) && !found_q;

    unique case (st_q)
      ST_IDLE: begin
        if (in_valid_i && in_ready_o) begin
          flags_d = dec_flags;
          plan_d  = dec_plan;
          type_d  = event_type_i;
          val_d   = event_value_i;
          fcode_d = dec_plan.fcode;
          idx_d   = '0;
          top_d   = '0;
          found_d = 1'b0;
          st_d    = ST_FIN;
          unique case (dec_plan.act)
            ACT_PUSH: begin
              // free slot at the fill count
              mem_we     = 1'b1;
              mem_waddr  = held_cnt_q[ADDR_W-1:0];
              mem_wdata  = dec_plan.dv;
              held_cnt_d = held_cnt_q + CNT_W'(1);
              fcode_d    = dec_plan.dv;
            end
            ACT_REPEAT, ACT_RELEASE: begin
              if (held_cnt_q != '0) begin
                st_d = ST_RD;
              end
            end
            ACT_NONE: begin
            end
          endcase
        end
      end
      ST_RD: begin
        mem_re    = 1'b1;
        mem_raddr = idx_q;
        st_d      = ST_CMP;
      end
      ST_CMP: begin
        if (plan_q.act == ACT_REPEAT) begin
          if (hit) begin
            fcode_d = plan_q.dv;
            st_d    = ST_FIN;
          end else if (last_ent) begin
            st_d = ST_FIN;
          end else begin
            idx_d = idx_q + ADDR_W'(1);
            st_d  = ST_RD;
          end
        end else begin
          // release: clear first match, track end of the occupied region
          if (hit) begin
            mem_we    = 1'b1;
            mem_waddr = idx_q;
            mem_wdata = '0;
            found_d   = 1'b1;
          end else if (mem_rdata != '0) begin
            top_d = idx_ext + CNT_W'(1);
          end
          if (last_ent) begin
            if (hit || found_q) begin
              held_cnt_d = top_d;
              fcode_d    = plan_q.dv;
            end
            st_d = ST_FIN;
          end else begin
            idx_d = idx_q + ADDR_W'(1);
            st_d  = ST_RD;
          end
        end
      end
      ST_FIN: begin
        emit_start = 1'b1;
        st_d       = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q       <= ST_IDLE;
      flags_q    <= '{lock: 1'b1, caps: 1'b0, ent: 1'b0, phase: 1'b0, mods: '0};
      held_cnt_q <= '0;
      idx_q      <= '0;
      top_q      <= '0;
      found_q    <= 1'b0;
    end else begin
      st_q       <= st_d;
      flags_q    <= flags_d;
      held_cnt_q <= held_cnt_d;
      idx_q      <= idx_d;
      top_q      <= top_d;
      found_q    <= found_d;
    end
  end

  always_ff @(posedge clk_i) begin
    plan_q  <= plan_d;
    type_q  <= type_d;
    val_q   <= val_d;
    fcode_q <= fcode_d;
  end

  always_comb begin
    emit_req.led1     = plan_q.led1;
    emit_req.led1_val = plan_q.led1_val;
    emit_req.led3     = plan_q.led3;
    emit_req.led3_val = plan_q.led3_val;
    emit_req.fwd      = plan_q.fwd;
    emit_req.ev_type  = type_q;
    emit_req.code     = fcode_q;
    emit_req.value    = val_q;
  end

  kbr_emit u_emit (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .start_i       (emit_start),
    .req_i         (emit_req),
    .busy_o        (emit_busy),
    .out_ready_i   (out_ready_i),
    .out_valid_o   (out_valid_o),
    .destination_o (destination_o),
    .out_type_o    (out_type_o),
    .out_code_o    (out_code_o),
    .out_value_o   (out_value_o),
    .last_o        (last_o)
  );

  assign push_acc = in_valid_i && in_ready_o && (dec_plan.act == ACT_PUSH);

  // fill count never passes the table size
  `KBR_NEVER(a_cnt_bound, clk_i, rst_ni, held_cnt_q > CNT_W'(TABLE_DEPTH))
  // the walk only looks at slots below the fill count
  `KBR_ASSERT(a_scan_in_range, clk_i, rst_ni, (st_q == ST_CMP) |-> (idx_ext < held_cnt_q))
  // a push grows the table by exactly one
  `KBR_ASSERT(a_push_grows, clk_i, rst_ni, push_acc |=> (held_cnt_q == $past(held_cnt_q) + CNT_W'(1)))
  // results are handed over only to an empty sequencer
  `KBR_ASSERT(a_start_idle, clk_i, rst_ni, (st_q == ST_FIN) |-> !emit_busy)

endmodule
`default_nettype wire

FILE: src/kbr_held_mem.sv
// Synchronous memory for the held remapped key codes.
`default_nettype none
module kbr_held_mem import kbr_pkg::*; #(
  parameter int unsigned DEPTH  = 32,
  parameter int unsigned ADDR_W = 5
) (
  input  wire logic              clk_i,
  input  wire logic              we_i,
  input  wire logic [ADDR_W-1:0] waddr_i,
  input  wire logic [CODE_W-1:0] wdata_i,
  input  wire logic              re_i,
  input  wire logic [ADDR_W-1:0] raddr_i,
  output      logic [CODE_W-1:0] rdata_o
);

  logic [CODE_W-1:0] mem_q [DEPTH];
  logic [CODE_W-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule
`default_nettype wire

FILE: src/kbr_evt_decode.sv
// Event decode: flag updates, LED writes and held-table action for one item.
`default_nettype none
module kbr_evt_decode import kbr_pkg::*; (
  input  wire logic              [TYPE_W-1:0] event_type_i,
  input  wire logic              [CODE_W-1:0] key_code_i,
  input  wire logic signed       [VAL_W-1:0]  event_value_i,
  input  wire logic                           toggle_en_i,
  input  wire logic                           dummy_en_i,
  input  wire logic                           table_full_i,
  input  wire flags_t                         flags_i,
  output      flags_t                         flags_o,
  output      plan_t                          plan_o
);

  logic              is_key;
  logic              v_press;
  logic              v_repeat;
  logic              v_release;
  logic [MOD_W-1:0]  mb;
  logic [CODE_W-1:0] dv;
  flags_t            nf;
  plan_t             p;

  always_comb begin
    is_key    = (event_type_i == EVT_KEY);
    v_press   = (event_value_i == VAL_PRESS);
    v_repeat  = (event_value_i == VAL_REPEAT);
    v_release = (event_value_i == VAL_RELEASE);
    mb        = mod_bit(key_code_i);
    dv        = dvorak_of(key_code_i);
    nf        = flags_i;

    p.led1     = 1'b0;
    p.led1_val = 1'b0;
    p.led3     = 1'b0;
    p.led3_val = 1'b0;
    p.fwd      = 1'b1;
    p.act      = ACT_NONE;
    p.dv       = dv;
    p.fcode    = key_code_i;
    if (is_key && key_code_i == K_SCROLL) begin
      p.fcode = K_KATA;
    end else if (is_key && key_code_i == K_CAPS) begin
      p.fcode = K_HIRA;
    end

    // lock selection on Scroll Lock press
    if (is_key && key_code_i == K_SCROLL && v_press) begin
      if (toggle_en_i) begin
        priority if ((flags_i.mods & MOD_CTRL_M) != '0) begin
          nf.lock = 1'b1;
          nf.ent  = 1'b0;
        end else if ((flags_i.mods & MOD_LALT) != '0) begin
          nf.lock = 1'b0;
          nf.ent  = 1'b0;
        end else if ((flags_i.mods & MOD_META_M) != '0) begin
          nf.lock = 1'b0;
          nf.ent  = 1'b1;
        end else begin
          nf.lock = ~flags_i.lock;
        end
      end else begin
        nf.lock = ~flags_i.lock;
        nf.ent  = 1'b0;
      end
    end

    if (nf.ent && is_key && v_press) begin
      if (key_code_i == K_ENTER) begin
        nf.lock = ~nf.lock;
      end else if (key_code_i == K_ESC) begin
        nf.lock = 1'b0;
      end
    end

    // LED write-back
    if (dummy_en_i) begin
      if ((is_key && v_press) || (event_type_i == EVT_LED && key_code_i != LED_DUMMY)) begin
        p.led1     = 1'b1;
        p.led1_val = nf.lock;
        p.led3     = 1'b1;
        p.led3_val = flags_i.phase;
        nf.phase   = ~flags_i.phase;
      end
    end else if ((is_key && key_code_i == K_CAPS) || event_type_i == EVT_LED) begin
      p.led1     = 1'b1;
      p.led1_val = nf.lock;
    end

    if (is_key) begin
      if (key_code_i == K_CAPS) begin
        nf.caps = !v_release;
      end
      if (mb != '0) begin
        nf.mods = v_release ? (nf.mods & ~mb) : (nf.mods | mb);
      end
      if (dv != key_code_i) begin
        if (v_press) begin
          if (nf.mods == '0 && nf.lock != nf.caps) begin
            if (table_full_i) begin
              p.fwd = 1'b0;
            end else begin
              p.act = ACT_PUSH;
            end
          end
        end else if (v_repeat) begin
          p.act = ACT_REPEAT;
        end else if (v_release) begin
          p.act = ACT_RELEASE;
        end
      end
    end

    flags_o = nf;
    plan_o  = p;
  end

endmodule
`default_nettype wire

FILE: src/kbr_emit.sv
// Result sequencer: LED writes then the forwarded event, through an output register.
`default_nettype none
module kbr_emit import kbr_pkg::*; (
  input  wire logic                      clk_i,
  input  wire logic                      rst_ni,
  input  wire logic                      start_i,
  input  wire emit_req_t                 req_i,
  output      logic                      busy_o,
  input  wire logic                      out_ready_i,
  output      logic                      out_valid_o,
  output      logic                      destination_o,
  output      logic        [TYPE_W-1:0]  out_type_o,
  output      logic        [CODE_W-1:0]  out_code_o,
  output      logic signed [VAL_W-1:0]   out_value_o,
  output      logic                      last_o
);

  pend_t                    pend_q, pend_d;
  emit_req_t                req_q, req_d;
  logic                     ovalid_q, ovalid_d;
  logic                     dst_q, dst_d;
  logic        [TYPE_W-1:0] type_q, type_d;
  logic        [CODE_W-1:0] code_q, code_d;
  logic signed [VAL_W-1:0]  val_q, val_d;
  logic                     last_q, last_d;
  logic                     slot_free;

  always_comb begin
    slot_free = !ovalid_q || out_ready_i;
    pend_d    = pend_q;
    req_d     = req_q;
    ovalid_d  = ovalid_q && !out_ready_i;
    dst_d     = dst_q;
    type_d    = type_q;
    code_d    = code_q;
    val_d     = val_q;
    last_d    = last_q;
    if (start_i) begin
      pend_d.led1 = req_i.led1;
      pend_d.led3 = req_i.led3;
      pend_d.fwd  = req_i.fwd;
      req_d       = req_i;
    end else if (slot_free && pend_q != '0) begin
      ovalid_d = 1'b1;
      priority if (pend_q.led1) begin
        dst_d       = 1'b1;
        type_d      = EVT_LED;
        code_d      = LED_LOCK;
        val_d       = {{(VAL_W-1){1'b0}}, req_q.led1_val};
        pend_d.led1 = 1'b0;
      end else if (pend_q.led3) begin
        dst_d       = 1'b1;
        type_d      = EVT_LED;
        code_d      = LED_DUMMY;
        val_d       = {{(VAL_W-1){1'b0}}, req_q.led3_val};
        pend_d.led3 = 1'b0;
      end else begin
        dst_d      = 1'b0;
        type_d     = req_q.ev_type;
        code_d     = req_q.code;
        val_d      = req_q.value;
        pend_d.fwd = 1'b0;
      end
      last_d = (pend_d == '0);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_q   <= '0;
      ovalid_q <= 1'b0;
    end else begin
      pend_q   <= pend_d;
      ovalid_q <= ovalid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    req_q  <= req_d;
    dst_q  <= dst_d;
    type_q <= type_d;
    code_q <= code_d;
    val_q  <= val_d;
    last_q <= last_d;
  end

  assign busy_o        = (pend_q != '0);
  assign out_valid_o   = ovalid_q;
  assign destination_o = dst_q;
  assign out_type_o    = type_q;
  assign out_code_o    = code_q;
  assign out_value_o   = val_q;
  assign last_o        = last_q;

endmodule
`default_nettype wire
